// ----- sv/tcce_pkg.sv -----
// Shared types and constants for the text console cell engine.
// Holds the transfer payload structs, operation and state codes and character constants.
// No dependencies.
package tcce_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 160;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    typedef enum logic [2:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_WRITE_AT   = 3'd1,
        OP_SET_CURSOR = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_READ_CELL  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [5:0] target_row;
        logic [7:0] target_col;
    } t_in_item;

    typedef struct packed {
        logic [5:0] cursor_row_now;
        logic [7:0] cursor_col_now;
        logic       cell_written;
        logic [5:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] cell_char;
        logic       scrolled;
        logic       ignored;
    } t_out_item;

    typedef struct packed {
        logic cell_we;
        logic cell_rd;
        logic scroll;
        logic clear;
    } t_exec_ctl;

endpackage

// ----- sv/text_console_cell_engine.sv -----
// Text console cell engine: MAX_ROWS x MAX_COLS character store in one RAM plus a cursor.
// After reset the block blanks the whole store, one cell per cycle, with o_in_stall high;
// configuration writes are taken meanwhile. Each accepted item yields one result.
// put_char without scroll, write_at, set_cursor and unknown operations pass through
// transfer in (IDLE) and execute (EXEC, with at most one store write); an in-range read_cell
// adds a READ state for the registered RAM read. A scroll walks the store through its single
// write port: (rows-1)*cols moves, then cols blank writes. clear writes rows*cols blanks.
// The next item is taken while the previous result still waits in the output register.
// Depends on tcce_pkg, tcce_decode and tcce_ram.
module text_console_cell_engine import tcce_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AR_W     = $clog2(MAX_ROWS + 1);
    localparam int AC_W     = $clog2(MAX_COLS + 1);
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int RST_COLS = (MAX_COLS < 160) ? MAX_COLS : 160;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [ROW_W-1:0] r_cur_row;
    logic [COL_W-1:0] r_cur_col;
    logic [AR_W-1:0]  r_rows, n_rows;
    logic [AC_W-1:0]  r_cols, n_cols;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;
    logic [AR_W-1:0]  r_sr, n_sr;
    logic [COL_W-1:0] r_sc, n_sc;
    logic             r_mv_valid, n_mv_valid;
    logic [ADDR_W-1:0] r_mv_addr;

    t_exec_ctl        dec_ctl;
    logic [ROW_W-1:0] dec_next_row;
    logic [COL_W-1:0] dec_next_col;
    logic [ROW_W-1:0] dec_cell_row;
    logic [COL_W-1:0] dec_cell_col;
    logic [7:0]       dec_cell_char;
    t_out_item        dec_res;

    logic             out_free;
    logic             scroll_blank;
    logic [AC_W-1:0]  lim_cols;
    logic             last_col;
    logic             last_row;
    logic             adv;
    logic             sweep_done;
    logic             fin;
    t_out_item        fin_item;

    logic [AR_W-1:0]   row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [ADDR_W:0]   addr_full;
    logic [ADDR_W-1:0] addr_a;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [7:0]        ram_rd_data;

    tcce_decode #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_decode (
        .i_item      (r_item),
        .i_cur_row   (r_cur_row),
        .i_cur_col   (r_cur_col),
        .i_rows      (r_rows),
        .i_cols      (r_cols),
        .o_ctl       (dec_ctl),
        .o_next_row  (dec_next_row),
        .o_next_col  (dec_next_col),
        .o_cell_row  (dec_cell_row),
        .o_cell_col  (dec_cell_col),
        .o_cell_char (dec_cell_char),
        .o_res       (dec_res)
    );

    tcce_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (addr_a),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Sweep bookkeeping shared by the blanking pass, clear and scroll
    assign scroll_blank = (r_sr == r_rows);
    assign lim_cols     = (r_state == ST_INIT) ? AC_W'(MAX_COLS) : r_cols;
    assign last_col     = (AC_W'(r_sc) == lim_cols - AC_W'(1));

    always_comb begin
        last_row   = 1'b0;
        adv        = 1'b0;
        sweep_done = 1'b0;
        case (r_state)
            ST_INIT: begin
                last_row   = (r_sr == AR_W'(MAX_ROWS - 1));
                adv        = 1'b1;
                sweep_done = last_col && last_row;
            end
            ST_CLEAR: begin
                last_row   = (r_sr == r_rows - AR_W'(1));
                adv        = 1'b1;
                sweep_done = last_col && last_row;
            end
            ST_SCROLL: begin
                // hold the blank pass while the last move drains
                adv        = !scroll_blank || !r_mv_valid;
                sweep_done = scroll_blank && !r_mv_valid && last_col;
            end
            default: begin
            end
        endcase
    end

    // Result completion
    always_comb begin
        fin      = 1'b0;
        fin_item = r_res;
        case (r_state)
            ST_EXEC: begin
                fin      = !dec_ctl.scroll && !dec_ctl.clear && !dec_ctl.cell_rd;
                fin_item = dec_res;
            end
            ST_READ: begin
                fin                = 1'b1;
                fin_item.cell_char = ram_rd_data;
            end
            ST_SCROLL, ST_CLEAR: begin
                fin = sweep_done;
            end
            ST_EMIT: begin
                fin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (dec_ctl.scroll) begin
                    n_state = ST_SCROLL;
                end else if (dec_ctl.clear) begin
                    n_state = ST_CLEAR;
                end else if (dec_ctl.cell_rd) begin
                    n_state = ST_READ;
                end else begin
                    n_state = out_free ? ST_IDLE : ST_EMIT;
                end
            end
            ST_READ, ST_SCROLL, ST_CLEAR, ST_EMIT: begin
                if (fin) begin
                    n_state = out_free ? ST_IDLE : ST_EMIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Store address, write port and sweep counters
    always_comb begin
        row_sel = r_sr;
        col_sel = r_sc;
        case (r_state)
            ST_EXEC: begin
                row_sel = AR_W'(dec_cell_row);
                col_sel = dec_cell_col;
            end
            ST_SCROLL: begin
                row_sel = scroll_blank ? r_sr - AR_W'(1) : r_sr;
            end
            default: begin
            end
        endcase
    end

    assign addr_full = (ADDR_W + 1)'(row_sel) * (ADDR_W + 1)'(MAX_COLS)
                     + (ADDR_W + 1)'(col_sel);
    assign addr_a    = addr_full[ADDR_W-1:0];

    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = addr_a;
        ram_wr_data = CH_BLANK;
        n_sr        = r_sr;
        n_sc        = r_sc;
        n_mv_valid  = r_mv_valid;
        case (r_state)
            ST_EXEC: begin
                ram_we      = dec_ctl.cell_we;
                ram_wr_data = dec_cell_char;
                n_sr        = dec_ctl.scroll ? AR_W'(1) : '0;
                n_sc        = '0;
                n_mv_valid  = 1'b0;
            end
            ST_INIT, ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_SCROLL: begin
                if (r_mv_valid) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = r_mv_addr;
                    ram_wr_data = ram_rd_data;
                end else if (scroll_blank) begin
                    ram_we = 1'b1;
                end
                n_mv_valid = !scroll_blank;
            end
            default: begin
            end
        endcase
        if (adv) begin
            if (last_col) begin
                n_sc = '0;
                n_sr = r_sr + AR_W'(1);
            end else begin
                n_sc = r_sc + COL_W'(1);
            end
        end
    end

    // Configuration: keep the clamped active counts
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE: begin
                    if (i_cfg_data[6:0] == 7'd0) begin
                        n_rows = AR_W'(1);
                    end else if (int'(i_cfg_data[6:0]) > MAX_ROWS) begin
                        n_rows = AR_W'(MAX_ROWS);
                    end else begin
                        n_rows = AR_W'(i_cfg_data[6:0]);
                    end
                end
                CFG_COLS_IN_USE: begin
                    if (i_cfg_data == 8'd0) begin
                        n_cols = AC_W'(1);
                    end else if (int'(i_cfg_data) > MAX_COLS) begin
                        n_cols = AC_W'(MAX_COLS);
                    end else begin
                        n_cols = AC_W'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_rows      <= AR_W'(RST_ROWS);
            r_cols      <= AC_W'(RST_COLS);
            r_out_valid <= 1'b0;
            r_sr        <= '0;
            r_sc        <= '0;
            r_mv_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
            r_sr       <= n_sr;
            r_sc       <= n_sc;
            r_mv_valid <= n_mv_valid;
            if (r_state == ST_EXEC) begin
                r_cur_row <= dec_next_row;
                r_cur_col <= dec_next_col;
            end
            if (fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == ST_EXEC) begin
            r_res <= dec_res;
        end else if (fin) begin
            r_res <= fin_item;
        end
        if (fin && out_free) begin
            r_out <= fin_item;
        end
        // destination of a move is the same column one row up
        r_mv_addr <= addr_a - ADDR_W'(MAX_COLS);
    end

endmodule

// ----- sv/tcce_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/tcce_decode.sv -----
// Operation decode for the text console cell engine: cursor update, cell access and result.
// Depends on tcce_pkg.
module tcce_decode import tcce_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int AR_W  = $clog2(MAX_ROWS + 1),
    localparam int AC_W  = $clog2(MAX_COLS + 1)
) (
    input  t_in_item         i_item,
    input  logic [ROW_W-1:0] i_cur_row,
    input  logic [COL_W-1:0] i_cur_col,
    input  logic [AR_W-1:0]  i_rows,
    input  logic [AC_W-1:0]  i_cols,
    output t_exec_ctl        o_ctl,
    output logic [ROW_W-1:0] o_next_row,
    output logic [COL_W-1:0] o_next_col,
    output logic [ROW_W-1:0] o_cell_row,
    output logic [COL_W-1:0] o_cell_col,
    output logic [7:0]       o_cell_char,
    output t_out_item        o_res
);

    localparam int CMP_W = 10;

    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;
    logic [ROW_W-1:0] cr;
    logic [COL_W-1:0] cc;
    logic             row_ok;
    logic             col_ok;
    logic [ROW_W-1:0] trow_cl;
    logic [COL_W-1:0] tcol_cl;
    logic [AR_W-1:0]  nr;
    logic [AC_W-1:0]  nc;
    logic             written;
    logic [5:0]       res_row;
    logic [7:0]       res_col;
    logic [7:0]       res_char;
    logic             scrolled;
    logic             ignored;

    assign rows_m1 = ROW_W'(i_rows - AR_W'(1));
    assign cols_m1 = COL_W'(i_cols - AC_W'(1));

    // put_char works on the cursor pulled back into the active area
    assign cr = (AR_W'(i_cur_row) >= i_rows) ? rows_m1 : i_cur_row;
    assign cc = (AC_W'(i_cur_col) >= i_cols) ? cols_m1 : i_cur_col;

    assign row_ok  = CMP_W'(i_item.target_row) < CMP_W'(i_rows);
    assign col_ok  = CMP_W'(i_item.target_col) < CMP_W'(i_cols);
    assign trow_cl = row_ok ? ROW_W'(i_item.target_row) : rows_m1;
    assign tcol_cl = col_ok ? COL_W'(i_item.target_col) : cols_m1;

    always_comb begin
        o_ctl       = '0;
        o_next_row  = i_cur_row;
        o_next_col  = i_cur_col;
        o_cell_row  = '0;
        o_cell_col  = '0;
        o_cell_char = CH_BLANK;
        nr          = AR_W'(cr);
        nc          = AC_W'(cc);
        written     = 1'b0;
        res_row     = '0;
        res_col     = '0;
        res_char    = '0;
        scrolled    = 1'b0;
        ignored     = 1'b0;
        case (i_item.operation)
            OP_PUT_CHAR: begin
                if (i_item.char_code == CH_NEWLINE) begin
                    nc = '0;
                    nr = AR_W'(cr) + AR_W'(1);
                end else if (i_item.char_code == CH_RETURN) begin
                    nc = '0;
                end else if (i_item.char_code == CH_BACKSPACE) begin
                    if (cc != '0) begin
                        nc            = AC_W'(cc) - AC_W'(1);
                        o_ctl.cell_we = 1'b1;
                        o_cell_row    = cr;
                        o_cell_col    = cc - COL_W'(1);
                        o_cell_char   = CH_BLANK;
                        written       = 1'b1;
                        res_row       = 6'(cr);
                        res_col       = 8'(cc - COL_W'(1));
                        res_char      = CH_BLANK;
                    end
                end else begin
                    o_ctl.cell_we = 1'b1;
                    o_cell_row    = cr;
                    o_cell_col    = cc;
                    o_cell_char   = i_item.char_code;
                    written       = 1'b1;
                    res_row       = 6'(cr);
                    res_col       = 8'(cc);
                    res_char      = i_item.char_code;
                    nc            = AC_W'(cc) + AC_W'(1);
                    if (nc >= i_cols) begin
                        nc = '0;
                        nr = AR_W'(cr) + AR_W'(1);
                    end
                end
                if (nr >= i_rows) begin
                    o_ctl.scroll = 1'b1;
                    scrolled     = 1'b1;
                    o_next_row   = rows_m1;
                    o_next_col   = '0;
                end else begin
                    o_next_row = ROW_W'(nr);
                    o_next_col = COL_W'(nc);
                end
            end
            OP_WRITE_AT: begin
                res_row = i_item.target_row;
                res_col = i_item.target_col;
                if (row_ok && col_ok) begin
                    o_ctl.cell_we = 1'b1;
                    o_cell_row    = ROW_W'(i_item.target_row);
                    o_cell_col    = COL_W'(i_item.target_col);
                    o_cell_char   = i_item.char_code;
                    written       = 1'b1;
                    res_char      = i_item.char_code;
                end else begin
                    ignored = 1'b1;
                end
            end
            OP_SET_CURSOR: begin
                o_next_row = trow_cl;
                o_next_col = tcol_cl;
            end
            OP_CLEAR: begin
                o_ctl.clear = 1'b1;
                o_next_row  = '0;
                o_next_col  = '0;
            end
            OP_READ_CELL: begin
                res_row = i_item.target_row;
                res_col = i_item.target_col;
                if (row_ok && col_ok) begin
                    o_ctl.cell_rd = 1'b1;
                    o_cell_row    = ROW_W'(i_item.target_row);
                    o_cell_col    = COL_W'(i_item.target_col);
                end else begin
                    ignored = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.cursor_row_now = 6'(o_next_row);
        o_res.cursor_col_now = 8'(o_next_col);
        o_res.cell_written   = written;
        o_res.cell_row       = res_row;
        o_res.cell_col       = res_col;
        o_res.cell_char      = res_char;
        o_res.scrolled       = scrolled;
        o_res.ignored        = ignored;
    end

endmodule
